>>> design/bom_sniffing_utf16_to_utf8_transcoder_unit_defines.svh
// Assertion macros shared by the transcoder RTL.
// All properties sample on clk_i; most are disabled while rst_ni is low.
`ifndef BOM_SNIFFING_UTF16_TO_UTF8_TRANSCODER_UNIT_DEFINES_SVH
`define BOM_SNIFFING_UTF16_TO_UTF8_TRANSCODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define B16U8_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define B16U8_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define B16U8_ASSERT(name, prop, msg)
`define B16U8_ASSERT_RST(name, prop, msg)
`endif
`endif

>>> design/b16u8_pkg.sv
package b16u8_pkg;

  localparam int unsigned MaxRes = 6;
  localparam int unsigned ResCntW = $clog2(MaxRes + 1);

  localparam logic [7:0] BomLeFirst   = 8'hFF;
  localparam logic [7:0] BomLeSecond  = 8'hFE;
  localparam logic [7:0] BomBeFirst   = 8'hFE;
  localparam logic [7:0] BomBeSecond  = 8'hFF;
  localparam logic [7:0] BomU8First   = 8'hEF;
  localparam logic [7:0] BomU8Second  = 8'hBB;
  localparam logic [7:0] BomU8Third   = 8'hBF;

  // top six bits of a UTF-16 code unit
  localparam logic [5:0] SurrHighTag  = 6'b110110;
  localparam logic [5:0] SurrLowTag   = 6'b110111;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_text;
  } out_t;

  // result list of one item, entry 0 goes out first
  typedef struct packed {
    logic [ResCntW-1:0]   n;
    out_t [MaxRes-1:0]    ent;
  } burst_t;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] bytes;
  } utf8_t;

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r.bytes = '0;
    if (cp < 21'h80) begin
      r.len      = 3'd1;
      r.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      r.len      = 3'd2;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      r.len      = 3'd3;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.len      = 3'd4;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

>>> design/b16u8_core.sv
// Mark detection, unit assembly and UTF-8 encode for one byte.
// State advances only when load_i is high.
module b16u8_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  b16u8_pkg::in_t    item_i,
  output b16u8_pkg::burst_t burst_o
);

  typedef enum logic [5:0] {
    ModeFirst  = 6'b000001,
    ModeSecond = 6'b000010,
    ModeThird  = 6'b000100,
    ModePass   = 6'b001000,
    ModeLe     = 6'b010000,
    ModeBe     = 6'b100000
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [7:0]  lead0_q, lead0_d, lead1_q, lead1_d;
  logic [7:0]  half_q, half_d;
  logic        half_held_q, half_held_d;
  logic [9:0]  hs_q, hs_d;
  logic        hs_held_q, hs_held_d;

  logic [7:0]        b;
  logic              last;
  logic [15:0]       unit;
  logic              is_high, is_low, paired;
  logic [20:0]       cp;
  logic [2:0][7:0]   seg_a;
  logic [2:0]        len_a, len_b, total, j;
  logic              pt_en;
  b16u8_pkg::utf8_t  enc;

  assign b    = item_i.in_byte;
  assign last = item_i.is_last;
  assign unit = (mode_q == ModeBe) ? {half_q, b} : {b, half_q};
  assign is_high = (unit[15:10] == b16u8_pkg::SurrHighTag);
  assign is_low  = (unit[15:10] == b16u8_pkg::SurrLowTag);
  assign paired  = hs_held_q && is_low;
  // 0x10000 + (hi << 10) + lo  ==  {hi + 64, lo}
  assign cp  = paired ? {({1'b0, hs_q} + 11'd64), unit[9:0]} : {5'd0, unit};
  assign enc = b16u8_pkg::utf8_encode(cp);
  assign len_b = pt_en ? enc.len : 3'd0;
  assign total = len_a + len_b;

  always_comb begin
    mode_d      = mode_q;
    lead0_d     = lead0_q;
    lead1_d     = lead1_q;
    half_d      = half_q;
    half_held_d = half_held_q;
    hs_d        = hs_q;
    hs_held_d   = hs_held_q;
    seg_a       = '0;
    len_a       = 3'd0;
    pt_en       = 1'b0;
    unique case (mode_q)
      ModeFirst: begin
        lead0_d = b;
        if (last) begin
          seg_a[0] = b;
          len_a    = 3'd1;
        end else begin
          mode_d = ModeSecond;
        end
      end
      ModeSecond: begin
        lead1_d = b;
        if (lead0_q == b16u8_pkg::BomLeFirst && b == b16u8_pkg::BomLeSecond) begin
          mode_d = ModeLe;
        end else if (lead0_q == b16u8_pkg::BomBeFirst && b == b16u8_pkg::BomBeSecond) begin
          mode_d = ModeBe;
        end else if (lead0_q == b16u8_pkg::BomU8First && b == b16u8_pkg::BomU8Second
                     && !last) begin
          mode_d = ModeThird;
        end else begin
          mode_d   = ModePass;
          seg_a[0] = lead0_q;
          seg_a[1] = b;
          len_a    = 3'd2;
        end
      end
      ModeThird: begin
        mode_d = ModePass;
        if (b != b16u8_pkg::BomU8Third) begin
          seg_a = {b, lead1_q, lead0_q};
          len_a = 3'd3;
        end
      end
      ModeLe, ModeBe: begin
        if (!half_held_q) begin
          half_d      = b;
          half_held_d = 1'b1;
          if (last && hs_held_q) begin
            seg_a = {{2'b10, hs_q[5:0]}, {4'hA, hs_q[9:6]}, 8'hED};
            len_a = 3'd3;
          end
        end else begin
          half_held_d = 1'b0;
          if (paired) begin
            pt_en     = 1'b1;
            hs_held_d = 1'b0;
          end else begin
            // a pending high surrogate without partner goes out on its own
            if (hs_held_q) begin
              seg_a     = {{2'b10, hs_q[5:0]}, {4'hA, hs_q[9:6]}, 8'hED};
              len_a     = 3'd3;
              hs_held_d = 1'b0;
            end
            if (is_high && !last) begin
              hs_d      = unit[9:0];
              hs_held_d = 1'b1;
            end else begin
              pt_en = 1'b1;
            end
          end
        end
      end
      default: begin
        seg_a[0] = b;
        len_a    = 3'd1;
      end
    endcase
    if (last) begin
      mode_d      = ModeFirst;
      half_held_d = 1'b0;
      hs_held_d   = 1'b0;
    end
  end

  always_comb begin
    burst_o.n = b16u8_pkg::ResCntW'(total);
    for (int k = 0; k < b16u8_pkg::MaxRes; k++) begin
      j = 3'(k) - len_a;
      burst_o.ent[k].out_byte    = (3'(k) < len_a) ? seg_a[(k < 3) ? 2'(k) : 2'd0]
                                                   : enc.bytes[j[1:0]];
      burst_o.ent[k].byte_valid  = 1'b1;
      burst_o.ent[k].end_of_text = last && (3'(k) == total - 3'd1);
    end
    if (last && total == 3'd0) begin
      // bare end marker
      burst_o.n      = b16u8_pkg::ResCntW'(1);
      burst_o.ent[0] = '{out_byte: 8'd0, byte_valid: 1'b0, end_of_text: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeFirst;
      half_held_q <= 1'b0;
      hs_held_q   <= 1'b0;
    end else if (load_i) begin
      mode_q      <= mode_d;
      half_held_q <= half_held_d;
      hs_held_q   <= hs_held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lead0_q <= lead0_d;
      lead1_q <= lead1_d;
      half_q  <= half_d;
      hs_q    <= hs_d;
    end
  end

endmodule

>>> design/bom_sniffing_utf16_to_utf8_transcoder_unit.sv
// An accepted input transaction passes through the input register, then the result register, to its first result.
// Throughput: one input transaction per cycle while the result register is free; an item that yields
//   n results holds the result register until all n have left (one output byte per cycle while not stalled).
// Rate is set by the result register draining its burst one byte a cycle while out_stall_i is low.
// Reset (rst_ni low, async): input register and burst empty, detector back to
//   awaiting the first byte of a text. No clearing pass.
`include "bom_sniffing_utf16_to_utf8_transcoder_unit_defines.svh"

module bom_sniffing_utf16_to_utf8_transcoder_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  b16u8_pkg::in_t     in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output b16u8_pkg::out_t    out_data_o
);

  localparam int unsigned IdxW = $clog2(b16u8_pkg::MaxRes);

  // input register
  logic              inq_vld_q;
  b16u8_pkg::in_t    inq_q;

  // result register: the whole result list of one item, drained in order
  logic [b16u8_pkg::ResCntW-1:0]        n_q;
  logic [IdxW-1:0]                      idx_q;
  b16u8_pkg::out_t [b16u8_pkg::MaxRes-1:0] ent_q;

  b16u8_pkg::burst_t burst;
  logic              out_fire, last_out, burst_free, load, in_fire;

  assign out_valid_o = (n_q != '0);
  assign out_data_o  = ent_q[idx_q];
  assign out_fire    = out_valid_o && !out_stall_i;
  assign last_out    = (b16u8_pkg::ResCntW'(idx_q) == n_q - b16u8_pkg::ResCntW'(1));
  // burst can take a new list when empty or once its final transaction leaves
  assign burst_free  = !out_valid_o || (out_fire && last_out);
  assign load        = inq_vld_q && burst_free;
  assign in_stall_o  = inq_vld_q && !burst_free;
  assign in_fire     = in_valid_i && !in_stall_o;

  b16u8_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .item_i  (inq_q),
    .burst_o (burst)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_vld_q <= 1'b0;
    end else if (in_fire) begin
      inq_vld_q <= 1'b1;
    end else if (load) begin
      inq_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      inq_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= '0;
      idx_q <= '0;
    end else if (load) begin
      n_q   <= burst.n;
      idx_q <= '0;
    end else if (out_fire) begin
      if (last_out) begin
        n_q <= '0;
      end else begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_q <= burst.ent;
    end
  end

  `B16U8_ASSERT(a_idx_in_range, out_valid_o |-> (b16u8_pkg::ResCntW'(idx_q) < n_q), "burst index past count")
  `B16U8_ASSERT(a_cnt_bound, n_q <= b16u8_pkg::ResCntW'(b16u8_pkg::MaxRes), "burst count exceeds six")
  `B16U8_ASSERT(a_eot_last, (out_valid_o && out_data_o.end_of_text) |-> last_out, "end_of_text before final entry")
  `B16U8_ASSERT(a_bare_eot, (out_valid_o && !out_data_o.byte_valid) |-> out_data_o.end_of_text, "bare result without end_of_text")
  `B16U8_ASSERT(a_stall_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(idx_q)), "stalled burst moved")

endmodule
